>>> design/lbc_pkg.sv
// ----------------------------------------------------------------------------
// LRU block cache package
// Sizes, field widths, operation codes and the request and response bundles
// shared by the entry store and the top level.
// ----------------------------------------------------------------------------
package lbc_pkg;

	// Cache geometry.
	localparam int CACHE_ENTRIES = 16;
	localparam int KEY_BITS      = 64;
	localparam int BLOCK_BITS    = 64;

	// Fixed widths of the stream fields.
	localparam int FIELD_W  = 64;
	localparam int S_DATA_W = 2 * FIELD_W;
	localparam int M_DATA_W = FIELD_W;

	// Recency rank width; one bit even for a single entry.
	localparam int AGE_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(CACHE_ENTRIES - 1);

	// Operation codes carried on the input tuser.
	typedef enum logic [0:0] {
		OP_PUT = 1'b0,
		OP_GET = 1'b1
	} op_t;

	// Request presented to the entry store; commit marks the cycle it takes effect.
	typedef struct packed {
		logic                  commit;
		op_t                   op;
		logic [KEY_BITS-1:0]   key;
		logic [BLOCK_BITS-1:0] data;
	} store_req_t;

	// Lookup result returned by the entry store.
	typedef struct packed {
		logic                  hit;
		logic [BLOCK_BITS-1:0] data;
	} store_rsp_t;

endpackage

>>> design/lru_block_cache.sv
// A result word passes the input register, then the result register, before it is
// offered; a stalled output can hold it in the input register.
// Throughput: one word per cycle while the output is not stalled, set by the parallel
// key compare and rank update over all entries.
// Reset: arst_n clears all valid marks and ranks, so the cache starts empty
// and is ready to accept as soon as reset is released.
// ----------------------------------------------------------------------------
// LRU block cache
// Fully associative put/get cache with least-recently-written replacement,
// stream input and output with one result word per input word.
// ----------------------------------------------------------------------------
module lru_block_cache (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [lbc_pkg::S_DATA_W-1:0] s_tdata,  // lookup_key[63:0], write_data[127:64]
	input  logic                         s_tuser,  // op[0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lbc_pkg::M_DATA_W-1:0] m_tdata,  // read_data[63:0]
	output logic                         m_tuser   // hit[0]
);
	import lbc_pkg::*;

	logic                  valid_s1;
	op_t                   op_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [BLOCK_BITS-1:0] data_s1;
	logic                  out_valid_q;
	logic                  hit_q;
	logic [M_DATA_W-1:0]   rdata_q;
	logic                  advance;
	store_req_t            req;
	store_rsp_t            rsp;

	// The input stage moves on whenever the result register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= op_t'(s_tuser);
			key_s1  <= s_tdata[KEY_BITS-1:0];
			data_s1 <= s_tdata[FIELD_W +: BLOCK_BITS];
		end
	end

	// Lookup and update.
	assign req.commit = advance;
	assign req.op     = op_s1;
	assign req.key    = key_s1;
	assign req.data   = data_s1;

	lbc_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q   <= rsp.hit;
			rdata_q <= M_DATA_W'(rsp.data);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = rdata_q;
	assign m_tuser  = hit_q;

endmodule

>>> design/lbc_store.sv
// ----------------------------------------------------------------------------
// LRU block cache entry store
// Holds the entries, matches the key against all of them in parallel and
// applies the put update with the recency ranks on a committed request.
// ----------------------------------------------------------------------------
module lbc_store (
	input  logic               clk,
	input  logic               arst_n,
	input  lbc_pkg::store_req_t req,
	output lbc_pkg::store_rsp_t rsp
);
	import lbc_pkg::*;

	logic [CACHE_ENTRIES-1:0]                 valid_q;
	logic [CACHE_ENTRIES-1:0][AGE_W-1:0]      age_q;
	logic [CACHE_ENTRIES-1:0][KEY_BITS-1:0]   key_q;
	logic [CACHE_ENTRIES-1:0][BLOCK_BITS-1:0] payload_q;

	logic [CACHE_ENTRIES-1:0] match;
	logic [CACHE_ENTRIES-1:0] free_vec;
	logic [CACHE_ENTRIES-1:0] free_first;
	logic [CACHE_ENTRIES-1:0] oldest_vec;
	logic [CACHE_ENTRIES-1:0] oldest_first;
	logic [CACHE_ENTRIES-1:0] victim;
	logic [CACHE_ENTRIES-1:0] young_vec;
	logic                     any_hit;
	logic [AGE_W-1:0]         hit_age;
	logic [BLOCK_BITS-1:0]    hit_data;
	logic                     do_put;

	// Per-entry compare; valid keys are unique, so at most one entry matches.
	always_comb begin
		for (int i = 0; i < CACHE_ENTRIES; i++) begin
			match[i]      = valid_q[i] && (key_q[i] == req.key);
			free_vec[i]   = !valid_q[i];
			oldest_vec[i] = valid_q[i] && (age_q[i] == AGE_OLDEST);
			young_vec[i]  = valid_q[i] && (age_q[i] == '0);
		end
	end

	// Merge the matching entry's payload and rank.
	always_comb begin
		hit_data = '0;
		hit_age  = '0;
		for (int i = 0; i < CACHE_ENTRIES; i++) begin
			if (match[i]) begin
				hit_data = hit_data | payload_q[i];
				hit_age  = hit_age | age_q[i];
			end
		end
	end

	assign any_hit = |match;

	// Victim: lowest free slot, else the oldest entry, else slot zero.
	assign free_first   = free_vec & (~free_vec + CACHE_ENTRIES'(1));
	assign oldest_first = oldest_vec & (~oldest_vec + CACHE_ENTRIES'(1));

	always_comb begin
		priority if (|free_vec) begin
			victim = free_first;
		end else if (|oldest_vec) begin
			victim = oldest_first;
		end else begin
			victim = CACHE_ENTRIES'(1);
		end
	end

	assign do_put = req.commit && (req.op == OP_PUT);

	// Response for the request in the input stage.
	assign rsp.hit  = any_hit;
	assign rsp.data = (req.op == OP_GET && any_hit) ? hit_data : '0;

	// Valid marks and recency ranks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			age_q   <= '0;
		end else if (do_put) begin
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				if (any_hit) begin
					if (match[i]) begin
						age_q[i] <= '0;
					end else if (valid_q[i] && age_q[i] < hit_age) begin
						age_q[i] <= age_q[i] + AGE_W'(1);
					end
				end else begin
					if (victim[i]) begin
						valid_q[i] <= 1'b1;
						age_q[i]   <= '0;
					end else if (valid_q[i]) begin
						age_q[i] <= age_q[i] + AGE_W'(1);
					end
				end
			end
		end
	end

	// Keys and payloads.
	always_ff @(posedge clk) begin
		if (do_put) begin
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				if (any_hit ? match[i] : victim[i]) begin
					payload_q[i] <= req.data;
				end
				if (!any_hit && victim[i]) begin
					key_q[i] <= req.key;
				end
			end
		end
	end

	// Keys among valid entries stay unique.
	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("more than one entry matches the key");

	// At most one valid entry can be the most recent.
	a_young_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(young_vec))
		else $error("several entries hold the most recent rank");

	// A get leaves the valid marks and ranks as they were.
	a_get_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(req.commit && req.op == OP_GET) |=> ($stable(age_q) && $stable(valid_q)))
		else $error("a get changed the recency state");

	// Entries are never dropped, only replaced.
	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) >= $countones($past(valid_q)))
		else $error("the number of valid entries shrank");

endmodule

>>> dv/lru_block_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU block cache testbench
// Drives put and get words with random gaps on both stream sides, tracks the
// cache contents and recency ranks in a shadow model, and compares every
// result word with the expected hit flag and read data.
// ----------------------------------------------------------------------------
module lru_block_cache_tb;
	import lbc_pkg::*;

	// One expected result word.
	typedef struct {
		logic                hit;
		logic [M_DATA_W-1:0] read_data;
	} cache_result_t;

	class block_cache_scoreboard;
		// Shadow copy of the cache state.
		bit                    line_valid [CACHE_ENTRIES];
		logic [KEY_BITS-1:0]   line_key   [CACHE_ENTRIES];
		logic [BLOCK_BITS-1:0] line_data  [CACHE_ENTRIES];
		int unsigned           line_rank  [CACHE_ENTRIES];

		cache_result_t expected_results[$];
		int unsigned   errors;
		int unsigned   put_count, get_count, hit_count, evict_count, checked_count;

		function new();
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				line_valid[i] = 1'b0;
				line_rank[i]  = 0;
			end
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		// Every valid line more recent than the limit moves one rank older.
		function void age_lines(int unsigned limit);
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				if (line_valid[i] && line_rank[i] < limit) line_rank[i]++;
			end
		endfunction

		// Apply an accepted input word to the shadow state and queue its result.
		function void note_request(op_t op, logic [FIELD_W-1:0] key_in,
				logic [FIELD_W-1:0] data_in);
			logic [KEY_BITS-1:0]   key;
			logic [BLOCK_BITS-1:0] data;
			cache_result_t         res;
			int                    found;
			int                    slot;
			int                    oldest;
			key    = key_in[KEY_BITS-1:0];
			data   = data_in[BLOCK_BITS-1:0];
			found  = -1;
			slot   = -1;
			oldest = -1;
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				if (found < 0 && line_valid[i] && line_key[i] == key) found = i;
			end
			res.hit       = (found >= 0);
			res.read_data = '0;
			if (res.hit) hit_count++;
			if (op == OP_GET) begin
				get_count++;
				if (found >= 0) res.read_data = M_DATA_W'(line_data[found]);
			end else begin
				put_count++;
				if (found >= 0) begin
					// Overwrite in place and make the line most recent.
					line_data[found] = data;
					age_lines(line_rank[found]);
					line_rank[found] = 0;
				end else begin
					// Lowest free slot, or the oldest line when the cache is full.
					for (int i = 0; i < CACHE_ENTRIES; i++) begin
						if (slot < 0 && !line_valid[i]) slot = i;
						if (oldest < 0 && line_valid[i] && line_rank[i] == CACHE_ENTRIES - 1)
							oldest = i;
					end
					if (slot < 0) begin
						slot = (oldest >= 0) ? oldest : 0;
						line_valid[slot] = 1'b0;
						evict_count++;
					end
					age_lines(CACHE_ENTRIES);
					line_valid[slot] = 1'b1;
					line_key[slot]   = key;
					line_data[slot]  = data;
					line_rank[slot]  = 0;
				end
			end
			expected_results.push_back(res);
		endfunction

		// Compare an accepted result word with the oldest expectation.
		function void check_result(logic hit, logic [M_DATA_W-1:0] read_data);
			cache_result_t exp_res;
			if (expected_results.size() == 0) begin
				$error("unexpected result word: hit %0d, read_data %h", hit, read_data);
				errors++;
				return;
			end
			exp_res = expected_results.pop_front();
			checked_count++;
			if (hit !== exp_res.hit) begin
				$error("hit mismatch: expected %0d, actual %0d", exp_res.hit, hit);
				errors++;
			end
			if (read_data !== exp_res.read_data) begin
				$error("read_data mismatch: expected %h, actual %h", exp_res.read_data,
						read_data);
				errors++;
			end
		endfunction
	endclass

	localparam int RANDOM_ITEMS = 1880;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;  // lookup_key[63:0], write_data[127:64]
	logic                s_tuser  = 1'b0;  // op[0]
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;  // read_data[63:0]
	logic                m_tuser;  // hit[0]

	block_cache_scoreboard sb = new();

	int unsigned idle_cycles = 0;
	bit          sender_burst = 1'b0;
	bit          receiver_burst = 1'b0;

	lru_block_cache i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Both handshakes are observed at the clock edge; the watchdog counts idle cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_request(op_t'(s_tuser), s_tdata[FIELD_W-1:0],
					s_tdata[S_DATA_W-1:FIELD_W]);
			if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [FIELD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic int unsigned sender_gap();
		return sender_burst ? 0 : $urandom_range(0, 19);
	endfunction

	// Present one word after a gap and hold it until it is taken.
	task automatic send_word(op_t op, logic [FIELD_W-1:0] key, logic [FIELD_W-1:0] data);
		int unsigned gap;
		gap = sender_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {data, key};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stop sending until every outstanding result has been returned.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Receiver: random stalls before each result, with stall-free stretches.
	initial begin
		int unsigned stall;
		int unsigned taken;
		taken = 0;
		wait (arst_n);
		forever begin
			if (taken % 50 == 0) receiver_burst = ($urandom_range(0, 3) == 0);
			stall = receiver_burst ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			taken++;
		end
	end

	// Directed words: empty miss, extreme keys and data, overwrite, fill and eviction.
	task automatic run_directed();
		send_word(OP_GET, '0, rand_word());
		send_word(OP_PUT, '0, '1);
		send_word(OP_GET, '0, '0);
		send_word(OP_PUT, '1, '0);
		send_word(OP_GET, '1, '1);
		send_word(OP_PUT, '0, 64'h0123_4567_89ab_cdef);
		// Fill the remaining lines; the all-ones key is now the oldest.
		for (int k = 1; k <= CACHE_ENTRIES - 2; k++) send_word(OP_PUT, FIELD_W'(k), rand_word());
		send_word(OP_PUT, 64'h8000_0000_0000_0000, '1);
		send_word(OP_GET, '1, '0);
		send_word(OP_GET, 64'd1, '0);
		send_word(OP_GET, '0, '0);
		send_word(OP_PUT, 64'd7, '0);
		send_word(OP_GET, 64'h8000_0000_0000_0000, '0);
	endtask

	// Random words in rounds, each round drawing from its own small key pool.
	task automatic run_random();
		logic [FIELD_W-1:0] key_pool[$];
		logic [FIELD_W-1:0] key;
		logic [FIELD_W-1:0] data;
		int unsigned        sent;
		int unsigned        pool_size;
		int unsigned        round_len;
		bit                 paused;
		op_t                op;
		sent   = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			pool_size = $urandom_range(2, 40);
			round_len = $urandom_range(40, 120);
			sender_burst = ($urandom_range(0, 3) == 0);
			key_pool.delete();
			for (int i = 0; i < pool_size; i++) key_pool.push_back(rand_word());
			for (int n = 0; n < round_len && sent < RANDOM_ITEMS; n++) begin
				op  = ($urandom_range(0, 99) < 45) ? OP_PUT : OP_GET;
				key = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, pool_size - 1)]
						: rand_word();
				case ($urandom_range(0, 9))
					0:       data = '0;
					1:       data = '1;
					default: data = rand_word();
				endcase
				send_word(op, key, data);
				sent++;
			end
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				wait_for_results();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d puts and %0d gets with %0d hits and %0d evictions.",
				sb.put_count, sb.get_count, sb.hit_count, sb.evict_count);
		$display("%0d result words were compared.", sb.checked_count);
		if (sb.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
